// ===== rtl/hpd_pkg.sv =====
// Shared types and constants of the heater PID duty controller.
// No dependencies; imported by every module of the block.
package hpd_pkg;

    localparam int W_POW      = 16;
    localparam int W_GAIN     = 32;
    localparam int W_Q        = 31;
    localparam int W_ERR      = 18;
    localparam int W_INTEG    = 32;
    localparam int W_CNT      = 4;
    localparam int W_PCT      = 7;
    localparam int W_CFG_IDX  = 3;
    localparam int W_CFG_DATA = 32;

    // Shared multiplier operand and product widths.
    localparam int W_MA = 34;
    localparam int W_MB = 32;
    localparam int W_MP = W_MA + W_MB;

    // Width of the wide signed sums of the duty-domain terms.
    localparam int W_WIDE = 52;

    localparam logic [W_CFG_IDX-1:0] CFG_TARGET_POWER = 3'd0;
    localparam logic [W_CFG_IDX-1:0] CFG_GAIN_PROP    = 3'd1;
    localparam logic [W_CFG_IDX-1:0] CFG_GAIN_INTEG   = 3'd2;
    localparam logic [W_CFG_IDX-1:0] CFG_GAIN_DERIV   = 3'd3;
    localparam logic [W_CFG_IDX-1:0] CFG_INTEG_LIMIT  = 3'd4;
    localparam logic [W_CFG_IDX-1:0] CFG_SLEW_LIMIT   = 3'd5;
    localparam logic [W_CFG_IDX-1:0] CFG_ERROR_BAND   = 3'd6;
    localparam logic [W_CFG_IDX-1:0] CFG_DUTY_CEILING = 3'd7;

    localparam logic [W_POW-1:0]  RST_TARGET_POWER = 16'd0;
    localparam logic [W_GAIN-1:0] RST_GAIN_PROP    = 32'd25770;
    localparam logic [W_GAIN-1:0] RST_GAIN_INTEG   = 32'd258;
    localparam logic [W_GAIN-1:0] RST_GAIN_DERIV   = 32'd2576980;
    localparam logic [W_Q-1:0]    RST_INTEG_LIMIT  = 31'd1073742;
    localparam logic [W_Q-1:0]    RST_SLEW_LIMIT   = 31'd32212255;
    localparam logic [W_POW-1:0]  RST_ERROR_BAND   = 16'd50;
    localparam logic [W_Q-1:0]    RST_DUTY_CEILING = 31'd1073741824;

    localparam logic [W_POW-1:0] TARGET_OFFSET = 16'd50;

    // ceil(2^35 / 10): exact tenth after a shift of 35, fifth after 34,
    // twentieth after 36, for any dividend below 2^34.
    localparam logic [W_MB-1:0] RECIP_TEN    = 32'hCCCC_CCCD;
    localparam logic [W_MB-1:0] PCT_SCALE    = 32'd100;
    localparam logic [W_MA-1:0] ROUND_TWENTY = 34'd19;
    localparam logic [W_PCT-1:0] PCT_MAX     = 7'd127;

    typedef struct packed {
        logic [W_POW-1:0]  target_power;
        logic [W_GAIN-1:0] gain_prop;
        logic [W_GAIN-1:0] gain_integ;
        logic [W_GAIN-1:0] gain_deriv;
        logic [W_Q-1:0]    integ_limit;
        logic [W_Q-1:0]    slew_limit;
        logic [W_POW-1:0]  error_band;
        logic [W_Q-1:0]    duty_ceiling;
    } t_cfg;

    typedef struct packed {
        logic [W_PCT-1:0] duty_percent;
        logic [W_Q-1:0]   duty_fraction;
        logic             in_band;
    } t_res;

endpackage

// ===== rtl/heater_pid_duty_controller_top.sv =====
// Top level of the heater PID duty controller: configuration registers,
// input and output handshakes and the output register. Depends on hpd_pkg
// and hpd_core.
//
// Usage: each input word (run enable, measured power) is taken when i_valid
// is high and o_stall is low; each word gives exactly one result word
// (duty in percent, duty as a Q1.30 fraction, stable flag), offered with
// o_valid and taken when i_stall is low.
// One word is worked on at a time, and o_stall stays high while it is.
// A full control step walks the shared multiplier through seven products
// under the sequencer, from the check state to the finish state; the next
// word can be taken only once the result has been loaded and the sequencer
// is idle again. With run low or a target below the minimum the step needs
// no products and goes from the check state straight to the finish state.
// The output register parts the two sides: a finished result waits there
// while i_stall is high, and the next input word is still taken; that word's
// result then waits in the sequencer until the register is free.
// Configuration words (register index and data) are taken in any cycle
// (o_cfg_ready is always high) and should be written only while idle.
// Reset (synchronous, active low) restores the register defaults, clears the
// duty, integral, last error, stable flag and counter, and empties the output.
module heater_pid_duty_controller_top
    import hpd_pkg::*;
#(
    parameter logic [15:0] MIN_POWER        = 16'd100,
    parameter logic [30:0] DUTY_FLOOR       = 31'd0,
    parameter logic [3:0]  UNSTABLE_SAMPLES = 4'd10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_run_enable,
    input  logic [W_POW-1:0]      i_measured_power,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [W_PCT-1:0]      o_duty_percent,
    output logic [W_Q-1:0]        o_duty_fraction,
    output logic                  o_in_band,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [W_CFG_IDX-1:0]  i_cfg_index,
    input  logic [W_CFG_DATA-1:0] i_cfg_data
);

    t_cfg r_cfg;
    t_res r_out;
    t_res w_res;
    logic r_out_valid;
    logic w_busy;
    logic w_accept;
    logic w_out_free;
    logic w_res_load;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_power <= RST_TARGET_POWER;
            r_cfg.gain_prop    <= RST_GAIN_PROP;
            r_cfg.gain_integ   <= RST_GAIN_INTEG;
            r_cfg.gain_deriv   <= RST_GAIN_DERIV;
            r_cfg.integ_limit  <= RST_INTEG_LIMIT;
            r_cfg.slew_limit   <= RST_SLEW_LIMIT;
            r_cfg.error_band   <= RST_ERROR_BAND;
            r_cfg.duty_ceiling <= RST_DUTY_CEILING;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TARGET_POWER: r_cfg.target_power <= i_cfg_data[W_POW-1:0];
                CFG_GAIN_PROP:    r_cfg.gain_prop    <= i_cfg_data;
                CFG_GAIN_INTEG:   r_cfg.gain_integ   <= i_cfg_data;
                CFG_GAIN_DERIV:   r_cfg.gain_deriv   <= i_cfg_data;
                CFG_INTEG_LIMIT:  r_cfg.integ_limit  <= i_cfg_data[W_Q-1:0];
                CFG_SLEW_LIMIT:   r_cfg.slew_limit   <= i_cfg_data[W_Q-1:0];
                CFG_ERROR_BAND:   r_cfg.error_band   <= i_cfg_data[W_POW-1:0];
                CFG_DUTY_CEILING: r_cfg.duty_ceiling <= i_cfg_data[W_Q-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_stall    = w_busy;
    assign w_accept   = i_valid && !w_busy;
    assign w_out_free = !r_out_valid || !i_stall;

    hpd_core #(
        .MIN_POWER        (MIN_POWER),
        .DUTY_FLOOR       (DUTY_FLOOR),
        .UNSTABLE_SAMPLES (UNSTABLE_SAMPLES)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_run_enable     (i_run_enable),
        .i_measured_power (i_measured_power),
        .i_cfg            (r_cfg),
        .i_out_free       (w_out_free),
        .o_busy           (w_busy),
        .o_res_load       (w_res_load),
        .o_res            (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_out <= w_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_duty_percent  = r_out.duty_percent;
    assign o_duty_fraction = r_out.duty_fraction;
    assign o_in_band       = r_out.in_band;

    // A taken word must hold off the next one until its step is done.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken but controller not busy in the next cycle");

    // A new result only appears at the end of a step.
    a_result_after_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result offered without a step in progress");

    // The percent figure must agree with a zero duty.
    a_zero_duty_percent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_duty_fraction == '0)) |-> (o_duty_percent == '0))
        else $error("non-zero percent with zero duty");

endmodule

// ===== rtl/hpd_mul.sv =====
// Shared unsigned multiplier of the controller with a registered product.
// Depends on hpd_pkg for the operand widths.
module hpd_mul
    import hpd_pkg::*;
(
    input  logic            i_clk,
    input  logic [W_MA-1:0] i_a,
    input  logic [W_MB-1:0] i_b,
    output logic [W_MP-1:0] o_prod
);

    logic [W_MP-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= W_MP'(i_a) * W_MP'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/hpd_core.sv =====
// Sequencer and datapath of the PID step: controller state and the operand
// schedule of the shared multiplier. Depends on hpd_pkg and hpd_mul.
module hpd_core
    import hpd_pkg::*;
#(
    parameter logic [W_POW-1:0] MIN_POWER        = 16'd100,
    parameter logic [W_Q-1:0]   DUTY_FLOOR       = 31'd0,
    parameter logic [W_CNT-1:0] UNSTABLE_SAMPLES = 4'd10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_run_enable,
    input  logic [W_POW-1:0] i_measured_power,
    input  t_cfg             i_cfg,
    input  logic             i_out_free,
    output logic             o_busy,
    output logic             o_res_load,
    output t_res             o_res
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_CHECK    = 4'd1;
    localparam logic [3:0] ST_MUL_P    = 4'd2;
    localparam logic [3:0] ST_MUL_I    = 4'd3;
    localparam logic [3:0] ST_MUL_D    = 4'd4;
    localparam logic [3:0] ST_SUM_PD   = 4'd5;
    localparam logic [3:0] ST_PREDICT  = 4'd6;
    localparam logic [3:0] ST_PICK_I   = 4'd7;
    localparam logic [3:0] ST_CHANGE   = 4'd8;
    localparam logic [3:0] ST_NEW_DUTY = 4'd9;
    localparam logic [3:0] ST_UPDATE   = 4'd10;
    localparam logic [3:0] ST_PERCENT  = 4'd11;
    localparam logic [3:0] ST_FINISH   = 4'd12;

    logic [3:0] r_state, n_state;

    // Controller state.
    logic [W_Q-1:0]            r_duty;
    logic signed [W_INTEG-1:0] r_integ;
    logic signed [W_ERR-1:0]   r_prev;
    logic                      r_stable;
    logic [W_CNT-1:0]          r_cnt;

    // Working registers of one step.
    logic                      r_run;
    logic [W_POW-1:0]          r_meas;
    logic signed [W_ERR-1:0]   r_e;
    logic signed [W_ERR-1:0]   r_de;
    logic signed [W_WIDE-1:0]  r_p;
    logic signed [W_WIDE-1:0]  r_acc;
    logic signed [W_INTEG-1:0] r_ni;
    logic signed [W_INTEG-1:0] r_ig;
    logic signed [W_INTEG-1:0] r_chg;
    logic                      r_sat;
    logic                      r_push;
    logic [W_Q-1:0]            r_nd;
    logic                      r_at_lim;
    t_res                      r_res;

    logic [W_MA-1:0] w_mul_a;
    logic [W_MB-1:0] w_mul_b;
    logic [W_MP-1:0] w_prod;

    hpd_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    logic signed [W_ERR-1:0]   w_err;
    logic signed [W_ERR-1:0]   w_derr;
    logic [W_ERR-1:0]          w_abs_e;
    logic [W_ERR-1:0]          w_abs_de;
    logic [W_INTEG-1:0]        w_abs_ni;
    logic [W_INTEG-1:0]        w_abs_ig;
    logic                      w_term_neg;
    logic signed [W_WIDE-1:0]  w_term_pos;
    logic signed [W_WIDE-1:0]  w_term;
    logic signed [W_WIDE-1:0]  w_lim;
    logic signed [W_WIDE-1:0]  w_ni_raw;
    logic signed [W_WIDE-1:0]  w_ni_sat;
    logic signed [W_WIDE-1:0]  w_pred;
    logic signed [W_WIDE-1:0]  w_ceil_w;
    logic signed [W_WIDE-1:0]  w_floor_w;
    logic                      w_pred_hi;
    logic                      w_pred_lo;
    logic                      w_e_pos;
    logic [W_INTEG-1:0]        w_q10;
    logic signed [W_INTEG-1:0] w_pick;
    logic [W_Q-1:0]            w_maxc;
    logic signed [W_WIDE-1:0]  w_maxc_w;
    logic signed [W_WIDE-1:0]  w_chg_raw;
    logic signed [W_WIDE-1:0]  w_chg_sat;
    logic                      w_quiet;
    logic signed [W_Q+1:0]     w_nd0;
    logic signed [W_Q+1:0]     w_nd1;
    logic signed [W_Q+1:0]     w_nd2;
    logic signed [W_Q+1:0]     w_ceil_n;
    logic signed [W_Q+1:0]     w_floor_n;
    logic [W_INTEG-1:0]        w_q20;
    logic [W_INTEG-1:0]        w_mag95;
    logic signed [W_INTEG-1:0] w_int95;
    logic                      w_in_band;
    logic [W_CNT-1:0]          w_cnt_inc;
    logic [8:0]                w_pct_raw;
    logic [W_PCT-1:0]          w_pct;

    assign w_err  = $signed({2'b00, i_cfg.target_power} + {2'b00, TARGET_OFFSET}
                            - {2'b00, r_meas});
    assign w_derr = w_err - r_prev;

    assign w_abs_e  = r_e[W_ERR-1]    ? W_ERR'(-r_e)     : W_ERR'(r_e);
    assign w_abs_de = r_de[W_ERR-1]   ? W_ERR'(-r_de)    : W_ERR'(r_de);
    assign w_abs_ni = r_ni[W_INTEG-1] ? W_INTEG'(-r_ni)  : W_INTEG'(r_ni);
    assign w_abs_ig = r_ig[W_INTEG-1] ? W_INTEG'(-r_ig)  : W_INTEG'(r_ig);
    assign w_e_pos  = !r_e[W_ERR-1] && (r_e != '0);

    // A gain product is Q34.32; keeping bits 49 to 2 gives Q18.30, toward zero.
    assign w_term_neg = (r_state == ST_SUM_PD) ? r_de[W_ERR-1] : r_e[W_ERR-1];
    assign w_term_pos = $signed({{(W_WIDE-48){1'b0}}, w_prod[49:2]});
    assign w_term     = w_term_neg ? -w_term_pos : w_term_pos;

    assign w_lim    = $signed({{(W_WIDE-W_Q){1'b0}}, i_cfg.integ_limit});
    assign w_ni_raw = W_WIDE'(r_integ) + w_term;

    always_comb begin
        if (w_ni_raw > w_lim) begin
            w_ni_sat = w_lim;
        end else if (w_ni_raw < -w_lim) begin
            w_ni_sat = -w_lim;
        end else begin
            w_ni_sat = w_ni_raw;
        end
    end

    assign w_ceil_w  = $signed({{(W_WIDE-W_Q){1'b0}}, i_cfg.duty_ceiling});
    assign w_floor_w = $signed({{(W_WIDE-W_Q){1'b0}}, DUTY_FLOOR});
    assign w_pred    = r_acc + $signed({{(W_WIDE-W_Q){1'b0}}, r_duty}) + W_WIDE'(r_ni);
    assign w_pred_hi = (w_pred >= w_ceil_w);
    assign w_pred_lo = (w_pred <= w_floor_w);

    // Three tenths of the clamped integral, on the magnitude.
    assign w_q10  = {1'b0, w_prod[65:35]};
    assign w_pick = r_ni[W_INTEG-1] ? -$signed(w_q10) : $signed(w_q10);

    // While stable the slew limit is a fifth of its set value.
    assign w_maxc    = r_stable ? w_prod[64:34] : i_cfg.slew_limit;
    assign w_maxc_w  = $signed({{(W_WIDE-W_Q){1'b0}}, w_maxc});
    assign w_chg_raw = r_acc + W_WIDE'(r_ig);
    assign w_quiet   = r_stable && ({1'b0, w_abs_e, 1'b0} < {4'b0000, i_cfg.error_band});

    always_comb begin
        if (w_quiet) begin
            w_chg_sat = '0;
        end else if (w_chg_raw > w_maxc_w) begin
            w_chg_sat = w_maxc_w;
        end else if (w_chg_raw < -w_maxc_w) begin
            w_chg_sat = -w_maxc_w;
        end else begin
            w_chg_sat = w_chg_raw;
        end
    end

    // Ceiling first, then floor, so a floor above the ceiling wins.
    assign w_ceil_n  = $signed({2'b00, i_cfg.duty_ceiling});
    assign w_floor_n = $signed({2'b00, DUTY_FLOOR});
    assign w_nd0     = (W_Q+2)'(r_chg) + $signed({2'b00, r_duty});
    assign w_nd1     = (w_nd0 > w_ceil_n) ? w_ceil_n : w_nd0;
    assign w_nd2     = (w_nd1 < w_floor_n) ? w_floor_n : w_nd1;

    // Nineteen twentieths of x is x minus the ceiling of x over twenty.
    assign w_q20   = {2'b00, w_prod[65:36]};
    assign w_mag95 = w_abs_ig - w_q20;
    assign w_int95 = r_ig[W_INTEG-1] ? -$signed(w_mag95) : $signed(w_mag95);

    assign w_in_band = ({1'b0, w_abs_e} < {3'b000, i_cfg.error_band});
    assign w_cnt_inc = r_cnt + 4'd1;

    assign w_pct_raw = w_prod[38:30];
    assign w_pct     = (w_pct_raw > {2'b00, PCT_MAX}) ? PCT_MAX : w_pct_raw[W_PCT-1:0];

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            ST_MUL_P: begin
                w_mul_a = {{(W_MA-W_ERR){1'b0}}, w_abs_e};
                w_mul_b = i_cfg.gain_prop;
            end
            ST_MUL_I: begin
                w_mul_a = {{(W_MA-W_ERR){1'b0}}, w_abs_e};
                w_mul_b = i_cfg.gain_integ;
            end
            ST_MUL_D: begin
                w_mul_a = {{(W_MA-W_ERR){1'b0}}, w_abs_de};
                w_mul_b = i_cfg.gain_deriv;
            end
            ST_PREDICT: begin
                w_mul_a = {2'b00, w_abs_ni} + {1'b0, w_abs_ni, 1'b0};
                w_mul_b = RECIP_TEN;
            end
            ST_PICK_I: begin
                w_mul_a = {3'b000, i_cfg.slew_limit};
                w_mul_b = RECIP_TEN;
            end
            ST_NEW_DUTY: begin
                w_mul_a = {2'b00, w_abs_ig} + ROUND_TWENTY;
                w_mul_b = RECIP_TEN;
            end
            ST_UPDATE: begin
                w_mul_a = {3'b000, r_nd};
                w_mul_b = PCT_SCALE;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!r_run || (i_cfg.target_power < MIN_POWER)) begin
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_MUL_P;
                end
            end
            ST_MUL_P:    n_state = ST_MUL_I;
            ST_MUL_I:    n_state = ST_MUL_D;
            ST_MUL_D:    n_state = ST_SUM_PD;
            ST_SUM_PD:   n_state = ST_PREDICT;
            ST_PREDICT:  n_state = ST_PICK_I;
            ST_PICK_I:   n_state = ST_CHANGE;
            ST_CHANGE:   n_state = ST_NEW_DUTY;
            ST_NEW_DUTY: n_state = ST_UPDATE;
            ST_UPDATE:   n_state = ST_PERCENT;
            ST_PERCENT:  n_state = ST_FINISH;
            ST_FINISH: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_duty   <= '0;
            r_integ  <= '0;
            r_prev   <= '0;
            r_stable <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_CHECK: begin
                    if (r_run && (i_cfg.target_power < MIN_POWER)) begin
                        r_duty   <= '0;
                        r_integ  <= '0;
                        r_stable <= 1'b0;
                    end else if (r_run) begin
                        r_prev <= w_err;
                    end
                end
                ST_UPDATE: begin
                    r_duty  <= r_nd;
                    r_integ <= r_at_lim ? w_int95 : r_ig;
                    if (w_in_band) begin
                        r_stable <= 1'b1;
                    end else if (w_cnt_inc >= UNSTABLE_SAMPLES) begin
                        r_cnt    <= '0;
                        r_stable <= 1'b0;
                    end else begin
                        r_cnt <= w_cnt_inc;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && (r_state == ST_IDLE)) begin
            r_run  <= i_run_enable;
            r_meas <= i_measured_power;
        end
        case (r_state)
            ST_CHECK: begin
                r_e  <= w_err;
                r_de <= w_derr;
                if (!r_run) begin
                    r_res <= '{duty_percent: '0, duty_fraction: '0, in_band: r_stable};
                end else begin
                    r_res <= '0;
                end
            end
            ST_MUL_I: begin
                r_p <= w_term;
            end
            ST_MUL_D: begin
                r_ni <= W_INTEG'(w_ni_sat);
            end
            ST_SUM_PD: begin
                r_acc <= r_p + w_term;
            end
            ST_PREDICT: begin
                r_sat  <= w_pred_hi || w_pred_lo;
                r_push <= (w_pred_hi && w_e_pos) || (w_pred_lo && r_e[W_ERR-1]);
            end
            ST_PICK_I: begin
                if (!r_sat) begin
                    r_ig <= r_ni;
                end else if (r_push) begin
                    r_ig <= w_pick;
                end else begin
                    r_ig <= r_integ;
                end
            end
            ST_CHANGE: begin
                r_chg <= W_INTEG'(w_chg_sat);
            end
            ST_NEW_DUTY: begin
                r_nd     <= w_nd2[W_Q-1:0];
                r_at_lim <= (w_nd2 >= w_ceil_n) || (w_nd2 <= w_floor_n);
            end
            ST_PERCENT: begin
                r_res <= '{duty_percent: w_pct, duty_fraction: r_duty, in_band: r_stable};
            end
            default: begin
            end
        endcase
    end

    assign o_busy     = (r_state != ST_IDLE);
    assign o_res_load = (r_state == ST_FINISH) && i_out_free;
    assign o_res      = r_res;

endmodule
